### design/rectilinear_grid_bilinear_sampler_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the rectilinear grid bilinear sampler
// Shorthand for implication checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef RECTILINEAR_GRID_BILINEAR_SAMPLER_ASSERT_SVH
`define RECTILINEAR_GRID_BILINEAR_SAMPLER_ASSERT_SVH

// same-cycle implication
`define RGBS_ASSERT_HOLDS(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RGBS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/rgbs_pkg.sv
// ----------------------------------------------------------------------------
// rgbs_pkg
// Shared types and constants of the rectilinear grid bilinear sampler.
// ----------------------------------------------------------------------------
package rgbs_pkg;

   localparam int MAX_X_POINTS = 64;
   localparam int MAX_Y_POINTS = 64;
   localparam int DATA_BITS    = 32;
   localparam int FRAC_BITS    = 30;
   localparam int IDX_BITS     = 6;
   localparam int CNT_BITS     = 7;
   localparam int QUO_BITS     = FRAC_BITS + 1;

   // request operation codes
   localparam logic [1:0] OP_LOAD_X = 2'd0;
   localparam logic [1:0] OP_LOAD_Y = 2'd1;
   localparam logic [1:0] OP_LOAD_V = 2'd2;
   localparam logic [1:0] OP_QUERY  = 2'd3;

   // register indexes
   localparam logic CSR_X_POINTS = 1'b0;
   localparam logic CSR_Y_POINTS = 1'b1;

   localparam logic signed [DATA_BITS-1:0] VALUE_MAX = {1'b0, {(DATA_BITS-1){1'b1}}};
   localparam logic signed [DATA_BITS-1:0] VALUE_MIN = {1'b1, {(DATA_BITS-1){1'b0}}};

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_FETCH,
      ST_DIV_WAIT,
      ST_DIFF,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_ROUND,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [IDX_BITS-1:0]         idx;
      logic signed [DATA_BITS-1:0] c0;
      logic signed [DATA_BITS-1:0] c1;
      logic signed [DATA_BITS-1:0] pe;
      logic                        outside;
   } search_result_type;

endpackage

### design/rgbs_axis_search.sv
// ----------------------------------------------------------------------------
// rgbs_axis_search
// Coordinate table of one axis with a linear cell search over its memory.
// ----------------------------------------------------------------------------
module rgbs_axis_search (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 wr_en,
   input  logic [rgbs_pkg::IDX_BITS-1:0]        wr_addr,
   input  logic signed [rgbs_pkg::DATA_BITS-1:0] wr_data,
   input  logic                                 start,
   input  logic [rgbs_pkg::CNT_BITS-1:0]        point_count,
   input  logic signed [rgbs_pkg::DATA_BITS-1:0] point,
   output logic                                 busy,
   output rgbs_pkg::search_result_type          result
);

   logic signed [rgbs_pkg::DATA_BITS-1:0] coord_mem [rgbs_pkg::MAX_X_POINTS];
   logic signed [rgbs_pkg::DATA_BITS-1:0] rd_data_ff;
   logic [rgbs_pkg::IDX_BITS-1:0]         rd_addr;
   logic                                  busy_ff;
   logic [rgbs_pkg::CNT_BITS-1:0]         issue_ff;
   logic [rgbs_pkg::CNT_BITS-1:0]         rk_ff;
   logic [rgbs_pkg::CNT_BITS-1:0]         count_ff;
   logic signed [rgbs_pkg::DATA_BITS-1:0] point_ff;
   logic signed [rgbs_pkg::DATA_BITS-1:0] prev_ff;
   logic signed [rgbs_pkg::DATA_BITS-1:0] t0_ff;
   logic signed [rgbs_pkg::DATA_BITS-1:0] t1_ff;
   rgbs_pkg::search_result_type           result_ff;
   rgbs_pkg::search_result_type           result_in;
   logic                                  hit;
   logic                                  last;
   logic                                  finish;
   logic [rgbs_pkg::IDX_BITS-1:0]         lower_idx;

   // write on load, read one entry a cycle during a search
   assign rd_addr = start ? '0 : issue_ff[rgbs_pkg::IDX_BITS-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         coord_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= coord_mem[rd_addr];
   end

   // pair check on the entry that just arrived and the one before it
   assign lower_idx = rk_ff[rgbs_pkg::IDX_BITS-1:0] - 1'b1;
   assign hit    = (rk_ff != '0) && (point_ff >= prev_ff) && (point_ff <= rd_data_ff);
   assign last   = (rk_ff == count_ff - 1'b1);
   assign finish = busy_ff && (hit || last);

   always_comb begin
      result_in = result_ff;
      if (hit) begin
         result_in.idx     = lower_idx;
         result_in.c0      = prev_ff;
         result_in.c1      = rd_data_ff;
         result_in.pe      = point_ff;
         result_in.outside = 1'b0;
      end else if (point_ff < t0_ff) begin
         result_in.idx     = '0;
         result_in.c0      = t0_ff;
         result_in.c1      = (rk_ff == 7'd1) ? rd_data_ff : t1_ff;
         result_in.pe      = t0_ff;
         result_in.outside = 1'b1;
      end else begin
         result_in.idx     = lower_idx;
         result_in.c0      = prev_ff;
         result_in.c1      = rd_data_ff;
         result_in.pe      = rd_data_ff;
         result_in.outside = 1'b1;
      end
   end

   // sequence the scan
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         issue_ff <= '0;
         rk_ff    <= '0;
      end else if (start) begin
         busy_ff  <= 1'b1;
         issue_ff <= 7'd1;
         rk_ff    <= '0;
      end else if (busy_ff) begin
         if (finish) begin
            busy_ff <= 1'b0;
         end else begin
            rk_ff    <= issue_ff;
            issue_ff <= issue_ff + 1'b1;
         end
      end
   end

   // hold scan data and the found cell
   always_ff @(posedge clock) begin
      if (start) begin
         point_ff <= point;
         count_ff <= point_count;
      end
      if (busy_ff) begin
         prev_ff <= rd_data_ff;
         if (rk_ff == '0) begin
            t0_ff <= rd_data_ff;
         end
         if (rk_ff == 7'd1) begin
            t1_ff <= rd_data_ff;
         end
         if (finish) begin
            result_ff <= result_in;
         end
      end
   end

   assign busy   = busy_ff;
   assign result = result_ff;

endmodule

### design/rgbs_frac_div.sv
// ----------------------------------------------------------------------------
// rgbs_frac_div
// Restoring divider for the cell fraction, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rgbs_frac_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [rgbs_pkg::DATA_BITS:0]  numer,
   input  logic [rgbs_pkg::DATA_BITS:0]  denom,
   output logic                          busy,
   output logic [rgbs_pkg::QUO_BITS-1:0] quotient
);

   localparam int REM_BITS = rgbs_pkg::DATA_BITS + 2;

   logic                          busy_ff;
   logic [4:0]                    step_ff;
   logic [REM_BITS-1:0]           rem_ff;
   logic [REM_BITS-1:0]           rem_in;
   logic [rgbs_pkg::DATA_BITS:0]  den_ff;
   logic [rgbs_pkg::QUO_BITS-1:0] quo_ff;
   logic                          ge;
   logic [REM_BITS-1:0]           sub;

   // trial subtract; remainder stays below the divisor
   assign ge     = rem_ff >= {1'b0, den_ff};
   assign sub    = ge ? rem_ff - {1'b0, den_ff} : rem_ff;
   assign rem_in = {sub[REM_BITS-2:0], 1'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         step_ff <= '0;
      end else if (busy_ff) begin
         if (step_ff == 5'(rgbs_pkg::QUO_BITS - 1)) begin
            busy_ff <= 1'b0;
         end else begin
            step_ff <= step_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= {1'b0, numer};
         den_ff <= denom;
         quo_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[rgbs_pkg::QUO_BITS-2:0], ge};
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

### design/rectilinear_grid_bilinear_sampler.sv
// ----------------------------------------------------------------------------
// rectilinear_grid_bilinear_sampler
// Loads coordinate tables and a value grid, then samples it bilinearly.
// ----------------------------------------------------------------------------
// A query runs the per-axis linear scan through the coordinate memories (one
// entry a cycle), a restoring divider per axis for the two cell fractions,
// and three interpolation steps on a shared split multiplier.
// Reset clears control state and restores the point counts to 64 and the
// running minimum and maximum; the memories are undefined until loaded.
module rectilinear_grid_bilinear_sampler (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_op,
   input  logic [5:0]         req_col_index,
   input  logic [5:0]         req_row_index,
   input  logic signed [31:0] req_load_data,
   input  logic signed [31:0] req_query_x,
   input  logic signed [31:0] req_query_y,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_sampled_value,
   output logic               rsp_outside_grid,
   output logic               rsp_degenerate_cell,
   output logic [5:0]         rsp_cell_column,
   output logic [5:0]         rsp_cell_row,
   output logic signed [31:0] rsp_grid_minimum,
   output logic signed [31:0] rsp_grid_maximum,
   input  logic               csr_write_enable,
   input  logic               csr_index,
   input  logic [6:0]         csr_write_data
);

   localparam int DB = rgbs_pkg::DATA_BITS;
   localparam int GA = 2 * rgbs_pkg::IDX_BITS;

   rgbs_pkg::state_type state_ff;
   rgbs_pkg::state_type state_in;

   logic [6:0]           xcount_ff;
   logic [6:0]           ycount_ff;
   logic [6:0]           xcount;
   logic [6:0]           ycount;
   logic signed [DB-1:0] min_ff;
   logic signed [DB-1:0] max_ff;
   logic signed [DB-1:0] grid_mem [rgbs_pkg::MAX_X_POINTS * rgbs_pkg::MAX_Y_POINTS];
   logic signed [DB-1:0] grid_rd_ff;
   logic [GA-1:0]        grid_raddr;
   logic [2:0]           fetch_ff;
   logic signed [DB-1:0] v00_ff;
   logic signed [DB-1:0] v01_ff;
   logic signed [DB-1:0] v10_ff;
   logic signed [DB-1:0] v11_ff;
   logic signed [DB-1:0] v4_ff;
   logic signed [DB-1:0] v5_ff;
   logic [1:0]           lsel_ff;

   logic                 accept;
   logic                 query_start;
   logic                 div_start;
   logic                 rsp_load;
   logic                 x_busy;
   logic                 y_busy;
   logic                 xdiv_busy;
   logic                 ydiv_busy;
   rgbs_pkg::search_result_type xres;
   rgbs_pkg::search_result_type yres;
   logic [rgbs_pkg::QUO_BITS-1:0] fx;
   logic [rgbs_pkg::QUO_BITS-1:0] fy;
   logic [DB:0]          x_num;
   logic [DB:0]          x_den;
   logic [DB:0]          y_num;
   logic [DB:0]          y_den;
   logic signed [DB:0]   sx_num;
   logic signed [DB:0]   sx_den;
   logic signed [DB:0]   sy_num;
   logic signed [DB:0]   sy_den;
   logic                 dx;
   logic                 dy;

   logic signed [DB-1:0] op_base;
   logic signed [DB-1:0] op_far;
   logic [rgbs_pkg::QUO_BITS-1:0] op_frac;
   logic                 op_degen;
   logic signed [DB:0]   diff;
   logic signed [DB-1:0] base_ff;
   logic [DB:0]          diffm_ff;
   logic                 neg_ff;
   logic [DB+16:0]       plo_ff;
   logic [DB+15:0]       phi_ff;
   logic [63:0]          prod;
   logic [33:0]          q;
   logic signed [35:0]   lerp_wide;
   logic signed [DB-1:0] lerp_sat;
   logic signed [DB-1:0] value_ff;

   logic                 rsp_valid_ff;
   logic signed [DB-1:0] rsp_value_ff;
   logic                 rsp_outside_ff;
   logic                 rsp_degen_ff;
   logic [5:0]           rsp_col_ff;
   logic [5:0]           rsp_row_ff;
   logic signed [DB-1:0] rsp_min_ff;
   logic signed [DB-1:0] rsp_max_ff;

   assign accept      = req_valid && req_ready;
   assign query_start = accept && (req_op == rgbs_pkg::OP_QUERY);

   // point count registers
   always_ff @(posedge clock) begin
      if (reset) begin
         xcount_ff <= 7'd64;
         ycount_ff <= 7'd64;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            rgbs_pkg::CSR_X_POINTS: xcount_ff <= csr_write_data;
            rgbs_pkg::CSR_Y_POINTS: ycount_ff <= csr_write_data;
         endcase
      end
   end

   // clamp the counts to the usable range
   assign xcount = (xcount_ff < 7'd2) ? 7'd2 :
                   (xcount_ff > 7'(rgbs_pkg::MAX_X_POINTS)) ?
                   7'(rgbs_pkg::MAX_X_POINTS) : xcount_ff;
   assign ycount = (ycount_ff < 7'd2) ? 7'd2 :
                   (ycount_ff > 7'(rgbs_pkg::MAX_Y_POINTS)) ?
                   7'(rgbs_pkg::MAX_Y_POINTS) : ycount_ff;

   // axis searches
   rgbs_axis_search u_xsearch (
      .clock       (clock),
      .reset       (reset),
      .wr_en       (accept && (req_op == rgbs_pkg::OP_LOAD_X)),
      .wr_addr     (req_col_index),
      .wr_data     (req_load_data),
      .start       (query_start),
      .point_count (xcount),
      .point       (req_query_x),
      .busy        (x_busy),
      .result      (xres)
   );

   rgbs_axis_search u_ysearch (
      .clock       (clock),
      .reset       (reset),
      .wr_en       (accept && (req_op == rgbs_pkg::OP_LOAD_Y)),
      .wr_addr     (req_row_index),
      .wr_data     (req_load_data),
      .start       (query_start),
      .point_count (ycount),
      .point       (req_query_y),
      .busy        (y_busy),
      .result      (yres)
   );

   // fraction operands: distance into the cell and cell width
   assign sx_num = {xres.pe[DB-1], xres.pe} - {xres.c0[DB-1], xres.c0};
   assign sx_den = {xres.c1[DB-1], xres.c1} - {xres.c0[DB-1], xres.c0};
   assign sy_num = {yres.pe[DB-1], yres.pe} - {yres.c0[DB-1], yres.c0};
   assign sy_den = {yres.c1[DB-1], yres.c1} - {yres.c0[DB-1], yres.c0};
   assign x_num  = sx_num[DB] ? (DB+1)'(0) - sx_num : sx_num;
   assign x_den  = sx_den[DB] ? (DB+1)'(0) - sx_den : sx_den;
   assign y_num  = sy_num[DB] ? (DB+1)'(0) - sy_num : sy_num;
   assign y_den  = sy_den[DB] ? (DB+1)'(0) - sy_den : sy_den;
   assign dx     = (xres.c1 == xres.c0);
   assign dy     = (yres.c1 == yres.c0);

   rgbs_frac_div u_xdiv (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (x_num),
      .denom    (x_den),
      .busy     (xdiv_busy),
      .quotient (fx)
   );

   rgbs_frac_div u_ydiv (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (y_num),
      .denom    (y_den),
      .busy     (ydiv_busy),
      .quotient (fy)
   );

   // grid memory: write on load, read the four cell corners in turn
   always_comb begin
      unique case (fetch_ff[1:0])
         2'd0:    grid_raddr = {yres.idx, xres.idx};
         2'd1:    grid_raddr = {yres.idx, xres.idx + 1'b1};
         2'd2:    grid_raddr = {yres.idx + 1'b1, xres.idx};
         default: grid_raddr = {yres.idx + 1'b1, xres.idx + 1'b1};
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept && (req_op == rgbs_pkg::OP_LOAD_V)) begin
         grid_mem[{req_row_index, req_col_index}] <= req_load_data;
      end
      grid_rd_ff <= grid_mem[grid_raddr];
   end

   // running minimum and maximum of loaded values
   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= rgbs_pkg::VALUE_MAX;
         max_ff <= rgbs_pkg::VALUE_MIN;
      end else if (accept && (req_op == rgbs_pkg::OP_LOAD_V)) begin
         if (req_load_data < min_ff) begin
            min_ff <= req_load_data;
         end
         if (req_load_data > max_ff) begin
            max_ff <= req_load_data;
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rgbs_pkg::ST_IDLE: begin
            if (query_start) begin
               state_in = rgbs_pkg::ST_SEARCH;
            end
         end
         rgbs_pkg::ST_SEARCH: begin
            if (!x_busy && !y_busy) begin
               state_in = rgbs_pkg::ST_FETCH;
            end
         end
         rgbs_pkg::ST_FETCH: begin
            if (fetch_ff == 3'd4) begin
               state_in = rgbs_pkg::ST_DIV_WAIT;
            end
         end
         rgbs_pkg::ST_DIV_WAIT: begin
            if (!xdiv_busy && !ydiv_busy) begin
               state_in = rgbs_pkg::ST_DIFF;
            end
         end
         rgbs_pkg::ST_DIFF:   state_in = rgbs_pkg::ST_MUL_LO;
         rgbs_pkg::ST_MUL_LO: state_in = rgbs_pkg::ST_MUL_HI;
         rgbs_pkg::ST_MUL_HI: state_in = rgbs_pkg::ST_ROUND;
         rgbs_pkg::ST_ROUND: begin
            state_in = (lsel_ff == 2'd2) ? rgbs_pkg::ST_DONE : rgbs_pkg::ST_DIFF;
         end
         rgbs_pkg::ST_DONE: begin
            if (rsp_load) begin
               state_in = rgbs_pkg::ST_IDLE;
            end
         end
         default: state_in = rgbs_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready = 1'b0;
      div_start = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         rgbs_pkg::ST_IDLE:   req_ready = 1'b1;
         rgbs_pkg::ST_SEARCH: div_start = !x_busy && !y_busy;
         rgbs_pkg::ST_DONE:   rsp_load  = !rsp_valid_ff || rsp_ready;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rgbs_pkg::ST_IDLE;
         fetch_ff <= '0;
         lsel_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (query_start) begin
            fetch_ff <= '0;
            lsel_ff  <= '0;
         end else if (state_ff == rgbs_pkg::ST_FETCH) begin
            fetch_ff <= fetch_ff + 1'b1;
         end else if (state_ff == rgbs_pkg::ST_ROUND) begin
            lsel_ff <= lsel_ff + 1'b1;
         end
      end
   end

   // capture corners as they return
   always_ff @(posedge clock) begin
      if (state_ff == rgbs_pkg::ST_FETCH) begin
         unique case (fetch_ff)
            3'd1: v00_ff <= grid_rd_ff;
            3'd2: v01_ff <= grid_rd_ff;
            3'd3: v10_ff <= grid_rd_ff;
            3'd4: v11_ff <= grid_rd_ff;
            default: begin
            end
         endcase
      end
   end

   // operands of the current interpolation step
   always_comb begin
      unique case (lsel_ff)
         2'd0: begin
            op_base = v00_ff; op_far = v01_ff; op_frac = fx; op_degen = dx;
         end
         2'd1: begin
            op_base = v10_ff; op_far = v11_ff; op_frac = fx; op_degen = dx;
         end
         default: begin
            op_base = v4_ff; op_far = v5_ff; op_frac = fy; op_degen = dy;
         end
      endcase
   end

   assign diff = {op_far[DB-1], op_far} - {op_base[DB-1], op_base};

   // combine partial products and round to nearest, ties away from zero
   assign prod      = 64'(plo_ff) + {phi_ff, 16'b0};
   assign q         = 34'((prod + (64'd1 << (rgbs_pkg::FRAC_BITS - 1)))
                          >> rgbs_pkg::FRAC_BITS);
   assign lerp_wide = neg_ff ? 36'(base_ff) - $signed({2'b0, q})
                             : 36'(base_ff) + $signed({2'b0, q});
   always_comb begin
      if (op_degen) begin
         lerp_sat = op_base;
      end else if (lerp_wide > 36'(rgbs_pkg::VALUE_MAX)) begin
         lerp_sat = rgbs_pkg::VALUE_MAX;
      end else if (lerp_wide < 36'(rgbs_pkg::VALUE_MIN)) begin
         lerp_sat = rgbs_pkg::VALUE_MIN;
      end else begin
         lerp_sat = lerp_wide[DB-1:0];
      end
   end

   // interpolation datapath
   always_ff @(posedge clock) begin
      unique case (state_ff)
         rgbs_pkg::ST_DIFF: begin
            base_ff  <= op_base;
            neg_ff   <= diff[DB];
            diffm_ff <= diff[DB] ? (DB+1)'(0) - diff : diff;
         end
         rgbs_pkg::ST_MUL_LO: plo_ff <= diffm_ff * op_frac[15:0];
         rgbs_pkg::ST_MUL_HI: phi_ff <= diffm_ff * op_frac[rgbs_pkg::QUO_BITS-1:16];
         rgbs_pkg::ST_ROUND: begin
            unique case (lsel_ff)
               2'd0:    v4_ff    <= lerp_sat;
               2'd1:    v5_ff    <= lerp_sat;
               default: value_ff <= lerp_sat;
            endcase
         end
         default: begin
         end
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_value_ff   <= value_ff;
         rsp_outside_ff <= xres.outside || yres.outside;
         rsp_degen_ff   <= dx || dy;
         rsp_col_ff     <= xres.idx;
         rsp_row_ff     <= yres.idx;
         rsp_min_ff     <= min_ff;
         rsp_max_ff     <= max_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_sampled_value   = rsp_value_ff;
   assign rsp_outside_grid    = rsp_outside_ff;
   assign rsp_degenerate_cell = rsp_degen_ff;
   assign rsp_cell_column     = rsp_col_ff;
   assign rsp_cell_row        = rsp_row_ff;
   assign rsp_grid_minimum    = rsp_min_ff;
   assign rsp_grid_maximum    = rsp_max_ff;

endmodule

### design/rgbs_checker.sv
// ----------------------------------------------------------------------------
// rgbs_checker
// Port-level checks of the sampler, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "rectilinear_grid_bilinear_sampler_assert.svh"

module rgbs_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] rsp_sampled_value,
   input logic [5:0]         rsp_cell_column,
   input logic [5:0]         rsp_cell_row,
   input logic signed [31:0] rsp_grid_minimum,
   input logic signed [31:0] rsp_grid_maximum
);

   // stalled response holds
   `RGBS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_sampled_value), "stalled response changed")

   // lower-left corner never on the last line
   `RGBS_ASSERT_HOLDS(a_cell_range, clock, reset, rsp_valid, rsp_cell_column != 6'd63 && rsp_cell_row != 6'd63, "cell index out of range")

   // reset leaves the block idle
   `RGBS_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid && req_ready, "not idle after reset")

   // once a value is loaded, minimum stays at or below maximum
   `RGBS_ASSERT_HOLDS(a_min_max, clock, reset, rsp_valid && rsp_grid_minimum != 32'sh7fffffff, rsp_grid_minimum <= rsp_grid_maximum, "running min above max")

endmodule

bind rectilinear_grid_bilinear_sampler rgbs_checker u_rgbs_checker (.*);
